FILE: sv/pthc_pkg.sv
package pthc_pkg;

  // fixed field widths
  localparam int SCREEN_W     = 16;
  localparam int CUBE_XY_W    = 17;
  localparam int CUBE_Z_W     = 18;
  localparam int MAP_COL_W    = 19;
  localparam int MAP_ROW_W    = 18;
  localparam int OFFSET_COL_W = 19;

  // tile registers and divisors
  localparam int TILE_W = 10;
  localparam int DEN_W  = TILE_W + 2;

  localparam logic [TILE_W-1:0] HEX_WIDTH_RST  = 10'd64;
  localparam logic [TILE_W-1:0] HEX_HEIGHT_RST = 10'd64;

  // register bus
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  typedef enum logic [0:0] {
    REG_HEX_WIDTH  = 1'b0,
    REG_HEX_HEIGHT = 1'b1
  } reg_idx_t;

  localparam int DEF_FRAC_BITS = 8;

  // stages after the divider: signs, sums, abs, round, sign back, rebuild, outputs
  localparam int POST_DIV_STAGES = 7;

  // numerator magnitude width: |2*screen_y| needs SCREEN_W+1 bits, then the fraction
  function automatic int quot_width(int frac_bits);
    return frac_bits + SCREEN_W + 1;
  endfunction

  // accept edge to the edge that loads the result registers
  function automatic int latency(int frac_bits);
    return quot_width(frac_bits) + POST_DIV_STAGES;
  endfunction

endpackage

FILE: sv/pthc_div.sv
module pthc_div import pthc_pkg::*; #(
  parameter int NUM_W = quot_width(DEF_FRAC_BITS),
  parameter int TAG_W = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [NUM_W-1:0] quot,
  output logic [TAG_W-1:0] tag_out
);

  // one quotient bit per stage, restoring long division
  logic             vld   [NUM_W];
  logic [DEN_W-1:0] rem   [NUM_W];
  logic [NUM_W-1:0] nsh   [NUM_W];
  logic [NUM_W-1:0] qacc  [NUM_W];
  logic [TAG_W-1:0] tag_s [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             vld_prev;
    logic [DEN_W-1:0] rem_prev;
    logic [NUM_W-1:0] nsh_prev;
    logic [NUM_W-1:0] q_prev;
    logic [TAG_W-1:0] tag_prev;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_prev = in_valid;
      assign rem_prev = '0;
      assign nsh_prev = num;
      assign q_prev   = '0;
      assign tag_prev = tag_in;
    end else begin : g_chain
      assign vld_prev = vld[k-1];
      assign rem_prev = rem[k-1];
      assign nsh_prev = nsh[k-1];
      assign q_prev   = qacc[k-1];
      assign tag_prev = tag_s[k-1];
    end

    always_comb begin
      trial = {rem_prev, nsh_prev[NUM_W-1]};
      ge    = trial >= {1'b0, den};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_prev;
      end
      rem[k]   <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      nsh[k]   <= {nsh_prev[NUM_W-2:0], 1'b0};
      qacc[k]  <= {q_prev[NUM_W-2:0], ge};
      tag_s[k] <= tag_prev;
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quot      = qacc[NUM_W-1];
  assign tag_out   = tag_s[NUM_W-1];

endmodule

FILE: sv/pixel_to_hex_cell_unit.sv
// Pixel to hex cell. Each request carries a signed screen position (screen_x, screen_y);
// the block returns the cube cell (cube_x, cube_y, cube_z), the axial map column and row,
// and the offset column. A request is taken on any cycle with start high; busy never rises,
// so one request can enter every clock. Its result appears on the result ports for one
// cycle, marked by done, after the long-division pipeline, one quotient bit per stage over
// FRAC_BITS + 17 stages, followed by seven stages of sign, sum, rounding and rebuild.
// The receiver cannot hold results off; results leave in request order. hex_width and
// hex_height (registers 0 and 1, byte addresses 0 and 4) should only be written while no
// request is in flight. A tile size of zero acts as one.
module pixel_to_hex_cell_unit import pthc_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  // request side
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SCREEN_W-1:0]     screen_x,
  input  logic signed [SCREEN_W-1:0]     screen_y,
  // result side
  output logic                           done,
  output logic signed [CUBE_XY_W-1:0]    cube_x,
  output logic signed [CUBE_XY_W-1:0]    cube_y,
  output logic signed [CUBE_Z_W-1:0]     cube_z,
  output logic signed [MAP_COL_W-1:0]    map_col,
  output logic signed [MAP_ROW_W-1:0]    map_row,
  output logic signed [OFFSET_COL_W-1:0] offset_col,
  // register bus
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [APB_ADDR_W-1:0]          paddr,
  input  logic [APB_DATA_W-1:0]          pwdata,
  output logic [APB_DATA_W-1:0]          prdata,
  output logic                           pready
);

  localparam int NW  = quot_width(FRAC_BITS);   // quotient / numerator width
  localparam int FW  = FRAC_BITS + 19;          // fixed point coordinate width
  localparam int RMW = FW - FRAC_BITS;          // rounded magnitude width
  localparam int RW  = RMW + 1;                 // rounded signed width

  localparam logic [FRAC_BITS:0] ONE_E  = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0] HALF_E = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
  localparam logic [FW-1:0]      HALF_F = FW'(HALF_E);

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  logic [TILE_W-1:0] hex_width;
  logic [TILE_W-1:0] hex_height;
  logic [DEN_W-1:0]  den_x;     // max(hex_width, 1)
  logic [DEN_W-1:0]  den_y;     // 3 * max(hex_height, 1)
  logic [TILE_W-1:0] wr_tile;
  logic              wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign wr_tile = (pwdata[TILE_W-1:0] == '0) ? TILE_W'(1) : pwdata[TILE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_width  <= HEX_WIDTH_RST;
      hex_height <= HEX_HEIGHT_RST;
      den_x      <= DEN_W'(HEX_WIDTH_RST);
      den_y      <= DEN_W'({HEX_HEIGHT_RST, 1'b0}) + DEN_W'(HEX_HEIGHT_RST);
    end else if (wr_en) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_HEX_WIDTH: begin
          hex_width <= pwdata[TILE_W-1:0];
          den_x     <= DEN_W'(wr_tile);
        end
        REG_HEX_HEIGHT: begin
          hex_height <= pwdata[TILE_W-1:0];
          den_y      <= DEN_W'({wr_tile, 1'b0}) + DEN_W'(wr_tile);
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_HEX_WIDTH:  prdata = APB_DATA_W'(hex_width);
      REG_HEX_HEIGHT: prdata = APB_DATA_W'(hex_height);
    endcase
  end

  // no backpressure anywhere: every stage moves every cycle
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // stage 0: magnitudes and signs of the numerators
  // ---------------------------------------------------------------------------
  logic                v0;
  logic [NW-1:0]       num_y0;   // |screen_y| * 2 << FRAC_BITS
  logic [NW-1:0]       num_x0;   // |screen_x| << FRAC_BITS
  logic [1:0]          sgn0;     // {y negative, x negative}
  logic [SCREEN_W-1:0] abs_x;
  logic [SCREEN_W-1:0] abs_y;

  // |-32768| is 0x8000 read as unsigned, which is right
  assign abs_x = screen_x[SCREEN_W-1] ? $unsigned(-screen_x) : $unsigned(screen_x);
  assign abs_y = screen_y[SCREEN_W-1] ? $unsigned(-screen_y) : $unsigned(screen_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    num_y0 <= {abs_y, (FRAC_BITS+1)'(0)};
    num_x0 <= {1'b0, abs_x, FRAC_BITS'(0)};
    sgn0   <= {screen_y[SCREEN_W-1], screen_x[SCREEN_W-1]};
  end

  // ---------------------------------------------------------------------------
  // divider pipelines, truncating toward zero on magnitudes
  // ---------------------------------------------------------------------------
  logic          dv;
  logic [NW-1:0] q_y;
  logic [NW-1:0] q_x;
  logic [1:0]    dsgn;

  pthc_div #(.NUM_W(NW), .TAG_W(2)) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .num       (num_y0),
    .den       (den_y),
    .tag_in    (sgn0),
    .out_valid (dv),
    .quot      (q_y),
    .tag_out   (dsgn)
  );

  // same depth as the y lane, so valid and signs come from there
  pthc_div #(.NUM_W(NW), .TAG_W(2)) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .num       (num_x0),
    .den       (den_x),
    .tag_in    (sgn0),
    .out_valid (),
    .quot      (q_x),
    .tag_out   ()
  );

  // ---------------------------------------------------------------------------
  // stage 1: signed quotients a (from y) and b (from x)
  // ---------------------------------------------------------------------------
  logic                 v1;
  logic signed [FW-1:0] a1;
  logic signed [FW-1:0] b1;
  logic signed [FW-1:0] qy_ext;
  logic signed [FW-1:0] qx_ext;

  assign qy_ext = $signed({{(FW-NW){1'b0}}, q_y});
  assign qx_ext = $signed({{(FW-NW){1'b0}}, q_x});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= dv;
    end
    a1 <= dsgn[1] ? -qy_ext : qy_ext;
    b1 <= dsgn[0] ? -qx_ext : qx_ext;
  end

  // ---------------------------------------------------------------------------
  // stage 2: fractional cube coordinates, index 0 x, 1 y, 2 z
  // ---------------------------------------------------------------------------
  logic                 v2;
  logic signed [FW-1:0] f2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    f2[0] <= a1 + b1;
    f2[1] <= a1 - b1;
    f2[2] <= -(a1 <<< 1);   // z = -x - y = -2a
  end

  // ---------------------------------------------------------------------------
  // stage 3: sign and magnitude
  // ---------------------------------------------------------------------------
  logic          v3;
  logic          neg3 [3];
  logic [FW-1:0] mag3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    for (int i = 0; i < 3; i++) begin
      neg3[i] <= f2[i][FW-1];
      mag3[i] <= f2[i][FW-1] ? $unsigned(-f2[i]) : $unsigned(f2[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: round half away from zero, rounding error from the fraction
  // ---------------------------------------------------------------------------
  logic               v4;
  logic               neg4  [3];
  logic [RMW-1:0]     rmag4 [3];
  logic [FRAC_BITS:0] err4  [3];
  logic [FRAC_BITS:0] frac3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      frac3[i] = {1'b0, mag3[i][FRAC_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    for (int i = 0; i < 3; i++) begin
      neg4[i]  <= neg3[i];
      rmag4[i] <= RMW'((mag3[i] + HALF_F) >> FRAC_BITS);
      // rounded up: error is one minus the fraction, else the fraction
      err4[i]  <= (frac3[i] >= HALF_E) ? ONE_E - frac3[i] : frac3[i];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: signed rounded coordinates
  // ---------------------------------------------------------------------------
  logic                 v5;
  logic signed [RW-1:0] r5   [3];
  logic [FRAC_BITS:0]   err5 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    for (int i = 0; i < 3; i++) begin
      r5[i]   <= neg4[i] ? -$signed({1'b0, rmag4[i]}) : $signed({1'b0, rmag4[i]});
      err5[i] <= err4[i];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: rebuild the coordinate with the largest error
  // ---------------------------------------------------------------------------
  logic                 v6;
  logic signed [RW-1:0] r6 [3];
  logic                 sel_x;
  logic                 sel_y;

  // ties: x only when strictly largest, then y when strictly above z, else z
  assign sel_x = (err5[0] > err5[1]) && (err5[0] > err5[2]);
  assign sel_y = !sel_x && (err5[1] > err5[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    r6[0] <= sel_x ? -r5[1] - r5[2] : r5[0];
    r6[1] <= sel_y ? -r5[0] - r5[2] : r5[1];
    r6[2] <= (!sel_x && !sel_y) ? -r5[0] - r5[1] : r5[2];
  end

  // ---------------------------------------------------------------------------
  // stage 7: map coordinates and result registers
  // ---------------------------------------------------------------------------
  logic signed [RW-1:0] col6;
  logic signed [RW-1:0] row6;
  logic signed [RW-1:0] ocol6;

  assign col6  = r6[0] + r6[2];
  assign row6  = -r6[2];
  assign ocol6 = col6 + (row6 >>> 1);   // arithmetic shift floors odd negative rows

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
    cube_x     <= r6[0][CUBE_XY_W-1:0];
    cube_y     <= r6[1][CUBE_XY_W-1:0];
    cube_z     <= r6[2][CUBE_Z_W-1:0];
    map_col    <= col6[MAP_COL_W-1:0];
    map_row    <= row6[MAP_ROW_W-1:0];
    offset_col <= ocol6[OFFSET_COL_W-1:0];
  end

endmodule

FILE: sv/pthc_checker.sv
module pthc_checker import pthc_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic signed [CUBE_XY_W-1:0]    cube_x,
  input logic signed [CUBE_XY_W-1:0]    cube_y,
  input logic signed [CUBE_Z_W-1:0]     cube_z,
  input logic signed [MAP_COL_W-1:0]    map_col,
  input logic signed [MAP_ROW_W-1:0]    map_row
);

  // done is sampled high at the edge after the edge that loads it
  localparam int LAT = latency(FRAC_BITS) + 1;

  logic signed [CUBE_Z_W-1:0]  z_sum;
  logic signed [MAP_ROW_W-1:0] row_chk;
  logic signed [MAP_COL_W-1:0] col_chk;

  assign z_sum   = -(CUBE_Z_W'(cube_x) + CUBE_Z_W'(cube_y));
  assign row_chk = -cube_z;
  assign col_chk = MAP_COL_W'(cube_x) + MAP_COL_W'(cube_z);

  // every accepted request gives a result after the fixed latency
  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted request produced no result");

  // no result without a request that fixed latency earlier
  a_done_from_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, LAT))
    else $error("result without matching request");

  // cube coordinates sum to zero
  a_cube_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (cube_z == z_sum))
    else $error("cube coordinates do not sum to zero");

  // axial coordinates follow from the cube cell
  a_axial: assert property (@(posedge clk) disable iff (rst)
    done |-> ((map_row == row_chk) && (map_col == col_chk)))
    else $error("axial coordinates disagree with cube cell");

endmodule

bind pixel_to_hex_cell_unit pthc_checker #(.FRAC_BITS(FRAC_BITS)) u_pthc_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .cube_x  (cube_x),
  .cube_y  (cube_y),
  .cube_z  (cube_z),
  .map_col (map_col),
  .map_row (map_row)
);
